// ===== rtl/core/sd_spi_host_sequencer_assert.svh =====
// assertion macros for the sd spi host sequencer checker
`ifndef SD_SPI_HOST_SEQUENCER_ASSERT_SVH
`define SD_SPI_HOST_SEQUENCER_ASSERT_SVH
`define SDS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define SDS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

// ===== rtl/core/sdspi_pkg.sv =====
// types and constants of the sd spi host sequencer
package sdspi_pkg;
  typedef enum logic [4:0] {
    PH_IDLE, PH_PWR, PH_CMD_SEND, PH_CMD_POLL, PH_CMD0_RETRY_GAP, PH_GAP_TO_CMD8, PH_R7,
    PH_GAP_TO_ACMD, PH_ACMD_NCR_GAP, PH_ACMD_TAIL_GAP, PH_ACMD_DELAY, PH_OCR,
    PH_GAP_AFTER_OCR, PH_GAP_TO_CMD59, PH_GAP_END_INIT, PH_TOKEN, PH_RD_DATA, PH_RD_CRC,
    PH_POST, PH_WR_GAP, PH_WR_TOKEN, PH_WR_WANT, PH_WR_SEND, PH_ZERO_SEND, PH_WF_CRC,
    PH_WF_RESP, PH_BUSY, PH_ERASE_GAP1, PH_ERASE_GAP2
  } phase_t;

  typedef enum logic [2:0] {K_INIT, K_READ, K_WRITE, K_ZERO, K_ERASE} kind_t;

  localparam logic [2:0] OP_XCHG  = 3'd0;
  localparam logic [2:0] OP_WDATA = 3'd1;
  localparam logic [2:0] OP_DELAY = 3'd2;
  localparam logic [2:0] OP_INIT  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_WRITE = 3'd5;
  localparam logic [2:0] OP_ZERO  = 3'd6;
  localparam logic [2:0] OP_ERASE = 3'd7;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_INIT    = 3'd2;
  localparam logic [2:0] ST_READ    = 3'd3;
  localparam logic [2:0] ST_WRITE   = 3'd4;

  localparam logic [2:0] REG_POLL  = 3'd0;
  localparam logic [2:0] REG_IDLE  = 3'd1;
  localparam logic [2:0] REG_INIT  = 3'd2;
  localparam logic [2:0] REG_TOKEN = 3'd3;
  localparam logic [2:0] REG_BUSY  = 3'd4;

  localparam logic [5:0] CMD0 = 6'd0;
  localparam logic [5:0] CMD8 = 6'd8;
  localparam logic [5:0] CMD16 = 6'd16;
  localparam logic [5:0] CMD17 = 6'd17;
  localparam logic [5:0] CMD24 = 6'd24;
  localparam logic [5:0] CMD32 = 6'd32;
  localparam logic [5:0] CMD33 = 6'd33;
  localparam logic [5:0] CMD38 = 6'd38;
  localparam logic [5:0] CMD41 = 6'd41;
  localparam logic [5:0] CMD55 = 6'd55;
  localparam logic [5:0] CMD58 = 6'd58;
  localparam logic [5:0] CMD59 = 6'd59;

  localparam int BLOCK_BYTES = 512;

  // output item, highest field first
  typedef struct packed {
    logic       high_capacity;
    logic [2:0] status;
    logic       done_res;
    logic       busy_res;
    logic       fast_clock;
    logic       delay_request;
    logic       want_write_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       chip_select;
    logic       mosi_valid;
    logic [7:0] mosi_byte;
  } res_t;
endpackage

// ===== rtl/core/sd_spi_host_sequencer.sv =====
// sd card spi-mode host sequencer, one step per spi byte exchange
//
// in_ channel: one item per step; tuser is the opcode, tdata holds miso_byte,
// write_byte, block_address and block_address_end. a start opcode begins an
// operation, byte-exchanged items answer each mosi request, write-data items
// answer want_write_byte and delay-elapsed items answer delay_request.
// out_ channel: one result item per input item, carrying the next request
// and status. the result is valid in the cycle after acceptance; one item per
// cycle holds while out_tready is high, set by the single registered state update.
// the output register is a one-entry stage: while the receiver stalls with
// a result pending, the input is held off, and an item is taken in the same
// cycle as the pending result is taken.
// cfg_ port: plain write of the five limit registers, effective at once.
// reset (rst_n low, synchronous) returns the sequencer to idle, the limits
// to their defaults, clears the capacity flag, fast clock and output valid.
module sd_spi_host_sequencer #(
  parameter int POWERUP_BYTES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // miso_byte[7:0], write_byte[15:8], block_address[47:16], block_address_end[79:48]
  input  logic [79:0] in_tdata,
  // opcode[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // mosi_byte, mosi_valid, chip_select, read_byte, read_valid, want_write_byte,
  // delay_request, fast_clock, busy_res, done_res, status[2:0], high_capacity, zero fill
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import sdspi_pkg::*;

  phase_t phase_r, phase_nxt;
  kind_t kind_r, kind_nxt;
  logic [9:0] byte_r, byte_nxt;
  logic [15:0] retry_r, retry_nxt, wait_r, wait_nxt;
  logic [47:0] frame_r, frame_nxt;
  logic [31:0] resp_r, resp_nxt, eend_r, eend_nxt;
  logic [7:0] r1_r, r1_nxt;
  logic blk_r, blk_nxt, fast_r, fast_nxt;
  logic [2:0] fst_r, fst_nxt;
  logic [7:0] poll_lim_r, idle_lim_r;
  logic [15:0] init_lim_r, tok_lim_r, busy_lim_r;
  logic ov_r;
  res_t res_r, res_nxt;

  logic [2:0] opc;
  logic [7:0] miso, wbyte;
  logic [31:0] addr, addr_end;
  logic acc, done;
  logic [2:0] stat;
  logic rdv;
  logic [7:0] rdb;

  assign opc = in_tuser;
  assign miso = in_tdata[7:0];
  assign wbyte = in_tdata[15:8];
  assign addr = in_tdata[47:16];
  assign addr_end = in_tdata[79:48];
  assign in_tready = !ov_r || out_tready;
  assign acc = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata = {4'd0, res_r};

  function automatic logic [47:0] frame(input logic [5:0] cmd, input logic [31:0] arg);
    logic [7:0] crc;
    crc = (cmd == CMD0) ? 8'h95 : ((cmd == CMD8) ? 8'h87 : 8'h01);
    return {2'b01, cmd, arg, crc};
  endfunction

  function automatic logic [15:0] lim8(input logic [7:0] v);
    return (v == 8'd0) ? 16'd1 : {8'd0, v};
  endfunction

  function automatic logic [15:0] lim16(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  always_comb begin
    logic [31:0] la;
    logic [31:0] lae;
    logic [15:0] w1;
    logic [15:0] rt1;
    logic [9:0] b1;
    logic [31:0] rw;
    logic endb;
    logic [2:0] bs;
    phase_t ph;
    phase_nxt = phase_r; kind_nxt = kind_r; byte_nxt = byte_r; retry_nxt = retry_r;
    wait_nxt = wait_r; frame_nxt = frame_r; resp_nxt = resp_r; eend_nxt = eend_r;
    r1_nxt = r1_r; blk_nxt = blk_r; fast_nxt = fast_r; fst_nxt = fst_r;
    done = 1'b0; stat = ST_OK; rdv = 1'b0; rdb = 8'd0;
    la = blk_r ? addr : {addr[22:0], 9'd0};
    lae = blk_r ? eend_r : {eend_r[22:0], 9'd0};
    w1 = wait_r + 16'd1;
    rt1 = retry_r + 16'd1;
    b1 = byte_r + 10'd1;
    rw = {resp_r[23:0], miso};
    endb = 1'b0; bs = ST_OK;
    if (phase_r == PH_IDLE) begin
      unique case (opc)
        OP_INIT: begin
          kind_nxt = K_INIT; phase_nxt = PH_PWR; byte_nxt = '0;
        end
        OP_READ: begin
          kind_nxt = K_READ; frame_nxt = frame(CMD17, la); byte_nxt = '0;
          phase_nxt = PH_CMD_SEND;
        end
        OP_WRITE: begin
          kind_nxt = K_WRITE; frame_nxt = frame(CMD24, la); byte_nxt = '0;
          phase_nxt = PH_CMD_SEND;
        end
        OP_ZERO: begin
          kind_nxt = K_ZERO; frame_nxt = frame(CMD24, la); byte_nxt = '0;
          phase_nxt = PH_CMD_SEND;
        end
        OP_ERASE: begin
          kind_nxt = K_ERASE; eend_nxt = addr_end; frame_nxt = frame(CMD32, la);
          byte_nxt = '0; phase_nxt = PH_CMD_SEND;
        end
        default: ;
      endcase
    end else if (phase_r == PH_WR_WANT) begin
      if (opc == OP_WDATA) begin
        resp_nxt = {24'd0, wbyte}; phase_nxt = PH_WR_SEND;
      end
    end else if (phase_r == PH_ACMD_DELAY) begin
      if (opc == OP_DELAY) begin
        retry_nxt = rt1;
        if (rt1 >= lim16(init_lim_r)) begin
          phase_nxt = PH_IDLE; done = 1'b1; stat = ST_INIT;
        end else begin
          frame_nxt = frame(CMD55, 32'd0); byte_nxt = '0; phase_nxt = PH_CMD_SEND;
        end
      end
    end else if (opc == OP_XCHG) begin
      unique case (phase_r)
        PH_PWR: begin
          byte_nxt = b1;
          if (b1 >= 10'(POWERUP_BYTES)) begin
            retry_nxt = '0; frame_nxt = frame(CMD0, 32'd0); byte_nxt = '0;
            phase_nxt = PH_CMD_SEND;
          end
        end
        PH_CMD_SEND: begin
          byte_nxt = b1;
          if (b1 >= 10'd6) begin
            phase_nxt = PH_CMD_POLL; wait_nxt = '0;
          end
        end
        PH_CMD_POLL: begin
          logic fin;
          logic [7:0] r1;
          fin = 1'b0; r1 = 8'hFF;
          if (miso != 8'hFF) begin
            fin = 1'b1; r1 = miso;
          end else begin
            wait_nxt = w1;
            if (w1 >= lim8(poll_lim_r)) fin = 1'b1;
          end
          if (fin) begin
            r1_nxt = r1;
            unique case (frame_r[45:40])
              CMD0: phase_nxt = (r1 == 8'h01) ? PH_GAP_TO_CMD8 : PH_CMD0_RETRY_GAP;
              CMD8: begin
                if (r1 == 8'h01) begin
                  phase_nxt = PH_R7; byte_nxt = '0; resp_nxt = '0;
                end else phase_nxt = PH_GAP_TO_ACMD;
              end
              CMD55: phase_nxt = (r1 != 8'hFF) ? PH_ACMD_NCR_GAP : PH_ACMD_TAIL_GAP;
              CMD41: phase_nxt = PH_ACMD_TAIL_GAP;
              CMD58: begin
                if (r1 != 8'd0) begin
                  phase_nxt = PH_IDLE; done = 1'b1; stat = ST_INIT;
                end else begin
                  phase_nxt = PH_OCR; byte_nxt = '0; resp_nxt = '0;
                end
              end
              CMD16: begin
                if (r1 != 8'd0) begin
                  phase_nxt = PH_IDLE; done = 1'b1; stat = ST_INIT;
                end else phase_nxt = PH_GAP_TO_CMD59;
              end
              CMD59: phase_nxt = PH_GAP_END_INIT;
              CMD17: begin
                if (r1 != 8'd0) begin
                  phase_nxt = PH_IDLE; done = 1'b1; stat = ST_READ;
                end else begin
                  phase_nxt = PH_TOKEN; wait_nxt = '0;
                end
              end
              CMD24: begin
                if (r1 != 8'd0) begin
                  phase_nxt = PH_IDLE; done = 1'b1; stat = ST_WRITE;
                end else phase_nxt = PH_WR_GAP;
              end
              CMD32: phase_nxt = PH_ERASE_GAP1;
              CMD33: phase_nxt = PH_ERASE_GAP2;
              CMD38: begin
                phase_nxt = PH_BUSY; wait_nxt = '0;
              end
              default: begin
                phase_nxt = PH_IDLE; done = 1'b1; stat = ST_OK;
              end
            endcase
          end
        end
        PH_CMD0_RETRY_GAP: begin
          retry_nxt = rt1;
          if (rt1 >= lim8(idle_lim_r)) begin
            phase_nxt = PH_IDLE; done = 1'b1; stat = ST_INIT;
          end else begin
            frame_nxt = frame(CMD0, 32'd0); byte_nxt = '0; phase_nxt = PH_CMD_SEND;
          end
        end
        PH_GAP_TO_CMD8: begin
          frame_nxt = frame(CMD8, 32'h0000_01AA); byte_nxt = '0; phase_nxt = PH_CMD_SEND;
        end
        PH_R7: begin
          resp_nxt = rw; byte_nxt = b1;
          if (b1 >= 10'd4) begin
            if (rw[7:0] != 8'hAA || rw[11:8] != 4'h1) begin
              phase_nxt = PH_IDLE; done = 1'b1; stat = ST_INIT;
            end else phase_nxt = PH_GAP_TO_ACMD;
          end
        end
        PH_GAP_TO_ACMD: begin
          retry_nxt = '0; frame_nxt = frame(CMD55, 32'd0); byte_nxt = '0;
          phase_nxt = PH_CMD_SEND;
        end
        PH_ACMD_NCR_GAP: begin
          frame_nxt = frame(CMD41, 32'h4000_0000); byte_nxt = '0; phase_nxt = PH_CMD_SEND;
        end
        PH_ACMD_TAIL_GAP: begin
          if (r1_r == 8'd0) begin
            frame_nxt = frame(CMD58, 32'd0); byte_nxt = '0; phase_nxt = PH_CMD_SEND;
          end else phase_nxt = PH_ACMD_DELAY;
        end
        PH_OCR: begin
          resp_nxt = rw; byte_nxt = b1;
          if (b1 >= 10'd4) begin
            blk_nxt = rw[30]; phase_nxt = PH_GAP_AFTER_OCR;
          end
        end
        PH_GAP_AFTER_OCR: begin
          frame_nxt = blk_r ? frame(CMD59, 32'd0) : frame(CMD16, 32'd512);
          byte_nxt = '0; phase_nxt = PH_CMD_SEND;
        end
        PH_GAP_TO_CMD59: begin
          frame_nxt = frame(CMD59, 32'd0); byte_nxt = '0; phase_nxt = PH_CMD_SEND;
        end
        PH_GAP_END_INIT: begin
          fast_nxt = 1'b1; phase_nxt = PH_IDLE; done = 1'b1; stat = ST_OK;
        end
        PH_TOKEN: begin
          if (miso == 8'hFE) begin
            phase_nxt = PH_RD_DATA; byte_nxt = '0;
          end else begin
            wait_nxt = w1;
            if (w1 >= lim16(tok_lim_r)) begin
              phase_nxt = PH_IDLE; done = 1'b1; stat = ST_TIMEOUT;
            end
          end
        end
        PH_RD_DATA: begin
          rdv = 1'b1; rdb = miso; byte_nxt = b1;
          if (b1 >= 10'(BLOCK_BYTES)) begin
            phase_nxt = PH_RD_CRC; byte_nxt = '0;
          end
        end
        PH_RD_CRC: begin
          byte_nxt = b1;
          if (b1 >= 10'd2) begin
            fst_nxt = ST_OK; phase_nxt = PH_POST;
          end
        end
        PH_POST: begin
          phase_nxt = PH_IDLE; done = 1'b1; stat = fst_r;
        end
        PH_WR_GAP: phase_nxt = PH_WR_TOKEN;
        PH_WR_TOKEN: begin
          byte_nxt = '0;
          phase_nxt = (kind_r == K_ZERO) ? PH_ZERO_SEND : PH_WR_WANT;
        end
        PH_WR_SEND, PH_ZERO_SEND: begin
          byte_nxt = b1;
          if (b1 >= 10'(BLOCK_BYTES)) begin
            phase_nxt = PH_WF_CRC; byte_nxt = '0;
          end else if (phase_r == PH_WR_SEND) phase_nxt = PH_WR_WANT;
        end
        PH_WF_CRC: begin
          byte_nxt = b1;
          if (b1 >= 10'd2) phase_nxt = PH_WF_RESP;
        end
        PH_WF_RESP: begin
          if (miso[4:0] != 5'h05) begin
            phase_nxt = PH_IDLE; done = 1'b1; stat = ST_WRITE;
          end else begin
            phase_nxt = PH_BUSY; wait_nxt = '0;
          end
        end
        PH_BUSY: begin
          if (miso == 8'hFF) endb = 1'b1;
          else begin
            wait_nxt = w1;
            if (w1 >= lim16(busy_lim_r)) begin
              endb = 1'b1; bs = ST_TIMEOUT;
            end
          end
          if (endb) begin
            fst_nxt = (kind_r == K_ERASE) ? ST_OK : bs; phase_nxt = PH_POST;
          end
        end
        PH_ERASE_GAP1: begin
          frame_nxt = frame(CMD33, lae); byte_nxt = '0; phase_nxt = PH_CMD_SEND;
        end
        PH_ERASE_GAP2: begin
          frame_nxt = frame(CMD38, 32'd0); byte_nxt = '0; phase_nxt = PH_CMD_SEND;
        end
        default: ;
      endcase
    end

    ph = phase_nxt;
    res_nxt.mosi_valid = !(ph == PH_IDLE || ph == PH_WR_WANT || ph == PH_ACMD_DELAY);
    res_nxt.chip_select = !(ph == PH_IDLE || ph == PH_PWR || ph == PH_POST);
    res_nxt.mosi_byte = 8'd0;
    if (res_nxt.mosi_valid) begin
      res_nxt.mosi_byte = 8'hFF;
      if (ph == PH_CMD_SEND) begin
        unique case (byte_nxt)
          10'd0: res_nxt.mosi_byte = frame_nxt[47:40];
          10'd1: res_nxt.mosi_byte = frame_nxt[39:32];
          10'd2: res_nxt.mosi_byte = frame_nxt[31:24];
          10'd3: res_nxt.mosi_byte = frame_nxt[23:16];
          10'd4: res_nxt.mosi_byte = frame_nxt[15:8];
          10'd5: res_nxt.mosi_byte = frame_nxt[7:0];
          default: res_nxt.mosi_byte = 8'hFF;
        endcase
      end else if (ph == PH_WR_TOKEN) res_nxt.mosi_byte = 8'hFE;
      else if (ph == PH_WR_SEND) res_nxt.mosi_byte = resp_nxt[7:0];
      else if (ph == PH_ZERO_SEND) res_nxt.mosi_byte = 8'd0;
    end
    res_nxt.read_byte = rdb;
    res_nxt.read_valid = rdv;
    res_nxt.want_write_byte = (ph == PH_WR_WANT);
    res_nxt.delay_request = (ph == PH_ACMD_DELAY);
    res_nxt.fast_clock = fast_nxt;
    res_nxt.busy_res = (ph != PH_IDLE);
    res_nxt.done_res = done;
    res_nxt.status = done ? stat : ST_OK;
    res_nxt.high_capacity = blk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; kind_r <= K_INIT; byte_r <= '0; retry_r <= '0; wait_r <= '0;
      frame_r <= '0; resp_r <= '0; eend_r <= '0; r1_r <= 8'hFF; blk_r <= 1'b0;
      fast_r <= 1'b0; fst_r <= ST_OK; ov_r <= 1'b0;
      poll_lim_r <= 8'd8; idle_lim_r <= 8'd10; init_lim_r <= 16'd1000;
      tok_lim_r <= 16'd200; busy_lim_r <= 16'd50000;
    end else begin
      if (acc) begin
        phase_r <= phase_nxt; kind_r <= kind_nxt; byte_r <= byte_nxt;
        retry_r <= retry_nxt; wait_r <= wait_nxt; frame_r <= frame_nxt;
        resp_r <= resp_nxt; eend_r <= eend_nxt; r1_r <= r1_nxt; blk_r <= blk_nxt;
        fast_r <= fast_nxt; fst_r <= fst_nxt; ov_r <= 1'b1;
      end else if (out_tready) ov_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POLL: poll_lim_r <= cfg_wdata[7:0];
          REG_IDLE: idle_lim_r <= cfg_wdata[7:0];
          REG_INIT: init_lim_r <= cfg_wdata;
          REG_TOKEN: tok_lim_r <= cfg_wdata;
          REG_BUSY: busy_lim_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) res_r <= res_nxt;
  end
endmodule

// ===== rtl/core/sdspi_checker.sv =====
// port-level checker for the sd spi host sequencer
`include "sd_spi_host_sequencer_assert.svh"
module sdspi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  logic       mv_w, ww_w, dr_w, busy_w, done_w;
  logic [2:0] st_w;

  assign mv_w = out_tdata[8];
  assign ww_w = out_tdata[19];
  assign dr_w = out_tdata[20];
  assign busy_w = out_tdata[22];
  assign done_w = out_tdata[23];
  assign st_w = out_tdata[26:24];

  `SDS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SDS_ASSERT_NXT(a_result_follows, clk, rst_n, in_tvalid && in_tready, out_tvalid)
  `SDS_ASSERT_IMP(a_one_request, clk, rst_n, out_tvalid, $onehot0({mv_w, ww_w, dr_w}))
  `SDS_ASSERT_IMP(a_done_idle, clk, rst_n, out_tvalid && done_w, !busy_w)
  `SDS_ASSERT_IMP(a_status_zero, clk, rst_n, out_tvalid && !done_w, st_w == 3'd0)
endmodule

bind sd_spi_host_sequencer sdspi_checker u_sdspi_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
